>>> rtl/core/j1939_bam_segmenter_top_defines.svh
// ---------------------------------------------------------------------------
// J1939 BAM segmenter assertion macros
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef J1939_BAM_SEGMENTER_TOP_DEFINES_SVH
`define J1939_BAM_SEGMENTER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge out of reset
`define BSEG_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bseg assertion failed");
// Condition must never be true out of reset
`define BSEG_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("bseg forbidden condition seen");
`else
`define BSEG_ASSERT(lbl, prop)
`define BSEG_NEVER(lbl, cond)
`endif

`endif

>>> rtl/core/bseg_pkg.sv
// ---------------------------------------------------------------------------
// bseg_pkg
// Shared types, constants and helper functions of the J1939 BAM segmenter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bseg_pkg;

    localparam int LEN_W  = 11;
    localparam int TIME_W = 64;
    localparam int DATA_W = 64;
    localparam int ID_W   = 29;
    localparam int GRP_W  = 18;
    localparam int SPC_W  = 32;

    localparam logic [LEN_W-1:0] MAX_PAYLOAD = 11'd1785;
    localparam logic [LEN_W-1:0] SINGLE_MAX  = 11'd8;

    localparam logic [GRP_W-1:0] TP_CM_GROUP = 18'h0EC00;
    localparam logic [GRP_W-1:0] TP_DT_GROUP = 18'h0EB00;
    localparam logic [2:0]       TP_PRIO     = 3'd7;
    localparam logic [7:0]       GLOBAL_DEST = 8'hFF;
    localparam logic [7:0]       BAM_CONTROL = 8'h20;
    localparam logic [7:0]       PDU2_FIRST  = 8'hF0;
    localparam logic [2:0]       LAST_SLOT   = 3'd6;

    // floor(x / 7) for x below 2048: multiply by ceil(2^15 / 7), keep bits 15 and up
    localparam logic [12:0] DIV7_MUL = 13'd4682;

    // Configuration register indexes
    localparam logic [1:0] CFG_GROUP   = 2'd0;
    localparam logic [1:0] CFG_SOURCE  = 2'd1;
    localparam logic [1:0] CFG_PRIO    = 2'd2;
    localparam logic [1:0] CFG_SPACING = 2'd3;

    typedef struct packed {
        logic [GRP_W-1:0] group_number;
        logic [7:0]       source_address;
        logic [2:0]       single_priority;
        logic [SPC_W-1:0] frame_spacing;
    } cfg_t;

    typedef struct packed {
        logic              start_req;
        logic [LEN_W-1:0]  payload_len;
        logic [TIME_W-1:0] start_time;
        logic [7:0]        byte_value;
    } item_t;

    typedef struct packed {
        logic [ID_W-1:0]   frame_id;
        logic [TIME_W-1:0] frame_time;
        logic [3:0]        frame_len;
        logic [DATA_W-1:0] frame_data;
        logic              last_frame;
    } frame_t;

    // Identifier: priority, group number, source; destination-specific groups go global
    function automatic logic [ID_W-1:0] make_id(input logic [GRP_W-1:0] grp,
                                               input logic [2:0] prio,
                                               input logic [7:0] src);
        logic [GRP_W-1:0] g;
        g = grp;
        if (g[15:8] < PDU2_FIRST)
        begin
            g[7:0] = GLOBAL_DEST;
        end
        return {prio, g, src};
    endfunction

    function automatic logic [DATA_W-1:0] put_byte(input logic [DATA_W-1:0] word,
                                                  input logic [2:0] pos,
                                                  input logic [7:0] v);
        logic [DATA_W-1:0] w;
        w = word;
        for (int i = 0; i < 8; i++)
        begin
            if (pos == 3'(i))
            begin
                w[i*8 +: 8] = v;
            end
        end
        return w;
    endfunction

    // Keep the first len bytes, clear the rest
    function automatic logic [DATA_W-1:0] keep_bytes(input logic [DATA_W-1:0] word,
                                                    input logic [3:0] len);
        logic [DATA_W-1:0] w;
        w = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) < len)
            begin
                w[i*8 +: 8] = word[i*8 +: 8];
            end
        end
        return w;
    endfunction

    // Number of seven-byte packets: ceil(len / 7)
    function automatic logic [7:0] packet_count(input logic [LEN_W-1:0] len);
        logic [11:0] x;
        logic [24:0] p;
        x = {1'b0, len} + 12'd6;
        p = 25'(x) * 25'(DIV7_MUL);
        return p[22:15];
    endfunction

endpackage

>>> rtl/core/bseg_cfg.sv
// ---------------------------------------------------------------------------
// bseg_cfg
// Configuration register file of the segmenter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bseg_cfg
    import bseg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [SPC_W-1:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.group_number    <= '0;
            cfg_reg.source_address  <= '0;
            cfg_reg.single_priority <= 3'd6;
            cfg_reg.frame_spacing   <= 32'd500000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GROUP:   cfg_reg.group_number    <= cfg_data[GRP_W-1:0];
                CFG_SOURCE:  cfg_reg.source_address  <= cfg_data[7:0];
                CFG_PRIO:    cfg_reg.single_priority <= cfg_data[2:0];
                CFG_SPACING: cfg_reg.frame_spacing   <= cfg_data;
                default:     cfg_reg.frame_spacing   <= cfg_reg.frame_spacing;
            endcase
        end
    end

endmodule

>>> rtl/core/bseg_ingress.sv
// ---------------------------------------------------------------------------
// bseg_ingress
// Input register: captures one request and holds it until the engine takes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bseg_ingress
    import bseg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              start_req,
    input  logic [LEN_W-1:0]  payload_len,
    input  logic [TIME_W-1:0] start_time,
    input  logic [7:0]        byte_value,
    input  logic              advance,
    output logic              item_valid,
    output item_t             item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    // Hold the request while the engine cannot advance
    assign in_stall   = valid_reg && !advance;
    assign take       = in_valid && !in_stall;
    assign valid_next = take || (valid_reg && !advance);

    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.start_req   <= start_req;
            item_reg.payload_len <= payload_len;
            item_reg.start_time  <= start_time;
            item_reg.byte_value  <= byte_value;
        end
    end

endmodule

>>> rtl/core/bseg_engine.sv
// ---------------------------------------------------------------------------
// bseg_engine
// Message state, frame assembly and the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "j1939_bam_segmenter_top_defines.svh"

module bseg_engine
    import bseg_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   item_valid,
    input  item_t  item,
    output logic   advance,
    input  logic   out_stall,
    output logic   out_valid,
    output frame_t frame
);

    logic              in_msg_reg,  in_msg_next;
    logic [LEN_W-1:0]  msg_len_reg, msg_len_next;
    logic [LEN_W-1:0]  rcv_reg,     rcv_next;
    logic [DATA_W-1:0] gather_reg,  gather_next;
    logic [7:0]        seq_reg,     seq_next;
    logic [TIME_W-1:0] time_reg,    time_next;
    logic [2:0]        pos_reg,     pos_next;
    logic              valid_reg,   valid_next;
    frame_t            res_reg,     res_next;

    logic              step;
    logic              produce;
    logic              emit_data;
    logic              proc;
    logic [LEN_W-1:0]  eff_len;
    logic [LEN_W-1:0]  eff_rcv;
    logic [DATA_W-1:0] eff_gather;
    logic [7:0]        eff_seq;
    logic [TIME_W-1:0] eff_time;
    logic [2:0]        eff_pos;
    logic [LEN_W-1:0]  rcv_inc;
    logic [DATA_W-1:0] g_single;
    logic [DATA_W-1:0] g_multi;
    logic [7:0]        seq_inc;
    logic              done;
    logic [TIME_W-1:0] time_inc;
    logic [DATA_W-1:0] announce;

    assign advance = !valid_reg || !out_stall;
    assign step    = item_valid && advance;

    // A start restarts the message context from the request itself
    assign eff_len    = item.start_req ? item.payload_len : msg_len_reg;
    assign eff_rcv    = item.start_req ? '0 : rcv_reg;
    assign eff_gather = item.start_req ? '1 : gather_reg;
    assign eff_seq    = item.start_req ? '0 : seq_reg;
    assign eff_time   = item.start_req ? item.start_time : time_reg;
    assign eff_pos    = item.start_req ? '0 : pos_reg;

    assign rcv_inc  = eff_rcv + 11'd1;
    assign done     = rcv_inc >= eff_len;
    assign seq_inc  = eff_seq + 8'd1;
    assign time_inc = eff_time + TIME_W'(cfg.frame_spacing);
    assign g_single = put_byte(eff_gather, eff_rcv[2:0], item.byte_value);
    assign g_multi  = put_byte(eff_gather, eff_pos + 3'd1, item.byte_value);

    assign announce = {{6'b0, cfg.group_number[17:16]}, cfg.group_number[15:8],
                       cfg.group_number[7:0], 8'hFF, packet_count(item.payload_len),
                       {5'b0, item.payload_len[10:8]}, item.payload_len[7:0], BAM_CONTROL};

    always_comb
    begin
        in_msg_next  = in_msg_reg;
        msg_len_next = msg_len_reg;
        rcv_next     = rcv_reg;
        gather_next  = gather_reg;
        seq_next     = seq_reg;
        time_next    = time_reg;
        pos_next     = pos_reg;
        produce      = 1'b0;
        emit_data    = 1'b0;
        proc         = 1'b0;
        res_next     = res_reg;

        if (item.start_req)
        begin
            in_msg_next  = 1'b0;
            rcv_next     = '0;
            gather_next  = '1;
            seq_next     = '0;
            time_next    = item.start_time;
            pos_next     = '0;
            msg_len_next = '0;
            if (item.payload_len <= MAX_PAYLOAD)
            begin
                msg_len_next = item.payload_len;
                if (item.payload_len == '0)
                begin
                    // Empty payload: one empty frame straight away
                    produce             = 1'b1;
                    res_next.frame_id   = make_id(cfg.group_number, cfg.single_priority,
                                                  cfg.source_address);
                    res_next.frame_time = item.start_time;
                    res_next.frame_len  = 4'd0;
                    res_next.frame_data = '0;
                    res_next.last_frame = 1'b1;
                end
                else
                begin
                    in_msg_next = 1'b1;
                    proc        = 1'b1;
                    if (item.payload_len > SINGLE_MAX)
                    begin
                        produce             = 1'b1;
                        res_next.frame_id   = make_id(TP_CM_GROUP, TP_PRIO,
                                                      cfg.source_address);
                        res_next.frame_time = item.start_time;
                        res_next.frame_len  = 4'd8;
                        res_next.frame_data = announce;
                        res_next.last_frame = 1'b0;
                    end
                end
            end
        end
        else
        begin
            proc = in_msg_reg;
        end

        if (proc)
        begin
            rcv_next = rcv_inc;
            if (eff_len <= SINGLE_MAX)
            begin
                if (done)
                begin
                    produce             = 1'b1;
                    res_next.frame_id   = make_id(cfg.group_number, cfg.single_priority,
                                                  cfg.source_address);
                    res_next.frame_time = eff_time;
                    res_next.frame_len  = eff_len[3:0];
                    res_next.frame_data = (eff_len == SINGLE_MAX) ? g_single
                                          : keep_bytes(g_single, eff_len[3:0]);
                    res_next.last_frame = 1'b1;
                    in_msg_next         = 1'b0;
                    gather_next         = '1;
                end
                else
                begin
                    gather_next = g_single;
                end
            end
            else if ((eff_pos == LAST_SLOT) || done)
            begin
                produce             = 1'b1;
                emit_data           = 1'b1;
                seq_next            = seq_inc;
                time_next           = time_inc;
                res_next.frame_id   = make_id(TP_DT_GROUP, TP_PRIO, cfg.source_address);
                res_next.frame_time = time_inc;
                res_next.frame_len  = 4'd8;
                res_next.frame_data = {g_multi[DATA_W-1:8], seq_inc};
                res_next.last_frame = done;
                gather_next         = '1;
                pos_next            = '0;
                if (done)
                begin
                    in_msg_next = 1'b0;
                end
            end
            else
            begin
                gather_next = g_multi;
                pos_next    = eff_pos + 3'd1;
            end
        end
    end

    assign valid_next = advance ? (item_valid && produce) : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_msg_reg  <= 1'b0;
            msg_len_reg <= '0;
            rcv_reg     <= '0;
            gather_reg  <= '1;
            seq_reg     <= '0;
            time_reg    <= '0;
            pos_reg     <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (step)
            begin
                in_msg_reg  <= in_msg_next;
                msg_len_reg <= msg_len_next;
                rcv_reg     <= rcv_next;
                gather_reg  <= gather_next;
                seq_reg     <= seq_next;
                time_reg    <= time_next;
                pos_reg     <= pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && produce)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign frame     = res_reg;

    `BSEG_ASSERT(a_single_count, (in_msg_reg && (msg_len_reg <= SINGLE_MAX)) |-> (rcv_reg < msg_len_reg))
    `BSEG_ASSERT(a_slot_range, (in_msg_reg && (msg_len_reg > SINGLE_MAX)) |-> (pos_reg <= LAST_SLOT))
    `BSEG_NEVER(a_open_len, in_msg_reg && ((msg_len_reg == '0) || (msg_len_reg > MAX_PAYLOAD)))
    `BSEG_ASSERT(a_last_closes, (step && produce && res_next.last_frame) |=> !in_msg_reg)
    `BSEG_ASSERT(a_gather_clear, (step && emit_data) |=> (gather_reg == '1))

endmodule

>>> rtl/core/j1939_bam_segmenter_top.sv
// ---------------------------------------------------------------------------
// j1939_bam_segmenter_top
// Splits a message into J1939 broadcast-announce transport CAN frames.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one payload byte per request;
//   the first request of a message has start_req set together with its
//   payload_len and start_time. Output channel (out_valid / out_stall) carries
//   at most one frame per request: single frame, announce or data frame.
//   Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes
//   group number, source address, single-frame priority and frame spacing;
//   cfg_ready is always high. Write registers only while the block is idle.
// Timing:
//   A taken request is held in the input register; the frame logic works on
//   it and its frame is loaded into the result register.
//   One request is taken every cycle unless out_stall holds a frame; the
//   single input register and the single result register set that rate.
// Reset:
//   rst_n clears the message state (no message open) and loads the register
//   defaults: priority 6, spacing 500000, group and source 0.
// Stall:
//   While out_stall holds a frame, the input register holds one request and
//   in_stall rises until the result register drains.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module j1939_bam_segmenter_top
    import bseg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // request channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              start_req,
    input  logic [LEN_W-1:0]  payload_len,
    input  logic [TIME_W-1:0] start_time,
    input  logic [7:0]        byte_value,
    // frame channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic [ID_W-1:0]   frame_id,
    output logic [TIME_W-1:0] frame_time,
    output logic [3:0]        frame_len,
    output logic [DATA_W-1:0] frame_data,
    output logic              last_frame,
    // configuration channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [SPC_W-1:0]  cfg_data
);

    cfg_t   cfg;
    item_t  item;
    logic   item_valid;
    logic   advance;
    frame_t frame;

    // Register file for the four configuration fields
    bseg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Hold each request in the input register until the engine advances
    bseg_ingress u_ingress (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .start_req   (start_req),
        .payload_len (payload_len),
        .start_time  (start_time),
        .byte_value  (byte_value),
        .advance     (advance),
        .item_valid  (item_valid),
        .item        (item)
    );

    // Advance the message state and load the frame into the result register
    bseg_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .frame      (frame)
    );

    assign frame_id   = frame.frame_id;
    assign frame_time = frame.frame_time;
    assign frame_len  = frame.frame_len;
    assign frame_data = frame.frame_data;
    assign last_frame = frame.last_frame;

endmodule

>>> tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the J1939 broadcast-announce segmenter. A frame
// tracker works out each frame from the accepted requests, and every frame
// the block hands out is compared with the oldest one still owed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import bseg_pkg::*;

    // Generous ceiling on the whole run, in clock cycles
    localparam int CYCLE_LIMIT = 400000;
    // Requests per random phase before the last message starts
    localparam int PHASE_REQUESTS = 75;
    localparam int PHASES = 8;
    // Bytes of the largest-length message that go out before it is abandoned
    localparam int LONG_CUT = 40;

    // -----------------------------------------------------------------------
    // Frame tracker: own copy of the segmenter state and registers, plus the
    // queue of frames still owed by the block.
    // -----------------------------------------------------------------------
    class bam_frame_tracker;
        cfg_t        regs;
        logic        open_msg;
        logic [10:0] msg_len;
        logic [10:0] byte_count;
        logic [63:0] gather_word;
        logic [7:0]  seq_no;
        logic [63:0] stamp;
        frame_t      frames_due[$];
        int          errors;

        function new();
            regs.group_number    = '0;
            regs.source_address  = '0;
            regs.single_priority = 3'd6;
            regs.frame_spacing   = 32'd500000;
            open_msg    = 1'b0;
            msg_len     = '0;
            byte_count  = '0;
            gather_word = '1;
            seq_no      = '0;
            stamp       = '0;
            errors      = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                CFG_GROUP:   regs.group_number    = val[GRP_W-1:0];
                CFG_SOURCE:  regs.source_address  = val[7:0];
                CFG_PRIO:    regs.single_priority = val[2:0];
                CFG_SPACING: regs.frame_spacing   = val;
                default:     ;
            endcase
        endfunction

        // Destination-specific groups carry the global address in the low byte
        function logic [ID_W-1:0] ident(logic [GRP_W-1:0] grp, logic [2:0] prio);
            logic [GRP_W-1:0] g;
            g = grp;
            if (g[15:8] < PDU2_FIRST)
            begin
                g[7:0] = GLOBAL_DEST;
            end
            return {prio, g, regs.source_address};
        endfunction

        function void owe_frame(logic [ID_W-1:0] id, logic [63:0] t, logic [3:0] len,
                                logic [63:0] data, logic last);
            frame_t f;
            f.frame_id   = id;
            f.frame_time = t;
            f.frame_len  = len;
            f.frame_data = data;
            f.last_frame = last;
            frames_due.push_back(f);
        endfunction

        function void take_request(item_t r);
            logic [7:0]  packets;
            logic [63:0] announce;
            int          slot;
            if (r.start_req)
            begin
                open_msg    = 1'b0;
                byte_count  = '0;
                gather_word = '1;
                seq_no      = '0;
                stamp       = r.start_time;
                if (r.payload_len > MAX_PAYLOAD)
                begin
                    msg_len = '0;
                    return;
                end
                msg_len = r.payload_len;
                if (msg_len == 0)
                begin
                    owe_frame(ident(regs.group_number, regs.single_priority), stamp,
                              4'd0, 64'd0, 1'b1);
                    return;
                end
                open_msg = 1'b1;
                if (msg_len > SINGLE_MAX)
                begin
                    packets  = 8'((int'(msg_len) + 6) / 7);
                    announce = {6'b0, regs.group_number[17:16], regs.group_number[15:8],
                                regs.group_number[7:0], 8'hFF, packets,
                                5'b0, msg_len[10:8], msg_len[7:0], BAM_CONTROL};
                    owe_frame(ident(TP_CM_GROUP, TP_PRIO), stamp, 4'd8, announce, 1'b0);
                end
            end
            else if (!open_msg)
            begin
                return;
            end

            if (msg_len <= SINGLE_MAX)
            begin
                gather_word[8 * int'(byte_count[2:0]) +: 8] = r.byte_value;
                byte_count++;
                if (byte_count >= msg_len)
                begin
                    // bytes beyond the length go out as zero
                    owe_frame(ident(regs.group_number, regs.single_priority), stamp,
                              msg_len[3:0],
                              gather_word & (64'hFFFF_FFFF_FFFF_FFFF >> (64 - 8 * int'(msg_len))),
                              1'b1);
                    open_msg    = 1'b0;
                    gather_word = '1;
                end
                return;
            end

            slot = int'(byte_count) % 7;
            gather_word[8 * (slot + 1) +: 8] = r.byte_value;
            byte_count++;
            if (slot == int'(LAST_SLOT) || byte_count >= msg_len)
            begin
                seq_no++;
                stamp += 64'(regs.frame_spacing);
                gather_word[7:0] = seq_no;
                owe_frame(ident(TP_DT_GROUP, TP_PRIO), stamp, 4'd8, gather_word,
                          byte_count >= msg_len);
                if (byte_count >= msg_len)
                begin
                    open_msg = 1'b0;
                end
                gather_word = '1;
            end
        endfunction

        function void match_frame(frame_t got);
            frame_t want;
            if (frames_due.size() == 0)
            begin
                $error("frame with nothing owed: frame_id %h frame_data %h",
                       got.frame_id, got.frame_data);
                errors++;
                return;
            end
            want = frames_due.pop_front();
            if (got.frame_id !== want.frame_id)
            begin
                $error("frame_id: expected %h, got %h", want.frame_id, got.frame_id);
                errors++;
            end
            if (got.frame_time !== want.frame_time)
            begin
                $error("frame_time: expected %h, got %h", want.frame_time, got.frame_time);
                errors++;
            end
            if (got.frame_len !== want.frame_len)
            begin
                $error("frame_len: expected %0d, got %0d", want.frame_len, got.frame_len);
                errors++;
            end
            if (got.frame_data !== want.frame_data)
            begin
                $error("frame_data: expected %h, got %h", want.frame_data, got.frame_data);
                errors++;
            end
            if (got.last_frame !== want.last_frame)
            begin
                $error("last_frame: expected %b, got %b", want.last_frame, got.last_frame);
                errors++;
            end
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // Block signals
    // -----------------------------------------------------------------------
    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic              start_req;
    logic [LEN_W-1:0]  payload_len;
    logic [TIME_W-1:0] start_time;
    logic [7:0]        byte_value;
    logic              out_valid;
    logic              out_stall;
    logic [ID_W-1:0]   frame_id;
    logic [TIME_W-1:0] frame_time;
    logic [3:0]        frame_len;
    logic [DATA_W-1:0] frame_data;
    logic              last_frame;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [1:0]        cfg_index;
    logic [SPC_W-1:0]  cfg_data;

    bam_frame_tracker tracker;
    frame_t           seen;
    logic             calm;       // high: neither side idles nor stalls
    int               msg_requests;
    int unsigned      cycles;

    j1939_bam_segmenter_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .start_req   (start_req),
        .payload_len (payload_len),
        .start_time  (start_time),
        .byte_value  (byte_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_id    (frame_id),
        .frame_time  (frame_time),
        .frame_len   (frame_len),
        .frame_data  (frame_data),
        .last_frame  (last_frame),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // 8 ns clock
    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Abandon the run if it drags on far beyond any correct run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver back-pressure: stall with a chance of about 22 in a hundred, change on
    // the falling edge so the block sees a settled value at the rising edge
    always @(negedge clk)
    begin
        out_stall = !calm && ($urandom_range(99) < 22);
    end

    // Every frame taken at a rising edge goes straight to the tracker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen = {frame_id, frame_time, frame_len, frame_data, last_frame};
            tracker.match_frame(seen);
        end
    end

    // -----------------------------------------------------------------------
    // Drivers; each is entered and left at a falling edge
    // -----------------------------------------------------------------------

    // Offer one request, idling first now and then; hold it until taken
    task automatic send_request(input logic s, input logic [LEN_W-1:0] len,
                                input logic [63:0] t, input logic [7:0] b);
        item_t req;
        // idle now and then, with a chance of about 22 in a hundred each time
        while (!calm && $urandom_range(99) < 22)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid    = 1'b1;
        start_req   = s;
        payload_len = len;
        start_time  = t;
        byte_value  = b;
        do
            @(posedge clk);
        while (in_stall);
        req = {s, len, t, b};
        tracker.take_request(req);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.write_reg(idx, val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Drop valid, wait for every owed frame, then let the pipeline settle
    // since the last request may have been one that makes no frame
    task automatic drain();
        in_valid = 1'b0;
        while (tracker.frames_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    // One message: a start request then payload bytes; cut stops it early so
    // the next start abandons it. Fields that a byte request ignores get junk.
    task automatic send_message(input int len, input int cut);
        logic [63:0] t0;
        int          full;
        int          n;
        int          pick;
        pick = $urandom_range(7);
        if (pick == 0)
        begin
            t0 = '0;
        end
        else if (pick <= 2)
        begin
            // just below the top, so the frame times wrap
            t0 = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom);
        end
        else
        begin
            t0 = {$urandom, $urandom};
        end
        full = (len == 0 || len > int'(MAX_PAYLOAD)) ? 1 : len;
        n    = (cut < full) ? cut : full;
        send_request(1'b1, LEN_W'(len), t0, 8'($urandom));
        for (int i = 1; i < n; i++)
        begin
            send_request(1'b0, LEN_W'($urandom), {$urandom, $urandom}, 8'($urandom));
        end
        msg_requests += n;
    endtask

    // Mostly short messages, some long ones, a few with an illegal length
    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 30)
        begin
            return $urandom_range(8, 0);
        end
        if (r < 80)
        begin
            return $urandom_range(40, 9);
        end
        if (r < 92)
        begin
            return $urandom_range(200, 41);
        end
        if (r < 97)
        begin
            return $urandom_range(2047, int'(MAX_PAYLOAD) + 1);
        end
        return $urandom_range(600, 201);
    endfunction

    // -----------------------------------------------------------------------
    // Test sequence
    // -----------------------------------------------------------------------
    initial
    begin
        logic [31:0] grp_val;
        logic [31:0] src_val;
        logic [31:0] prio_val;
        logic [31:0] spc_val;
        int          goal;
        int          len;
        int          cut;

        tracker      = new();
        calm         = 1'b0;
        msg_requests = 0;
        cycles       = 0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        start_req    = 1'b0;
        payload_len  = '0;
        start_time   = '0;
        byte_value   = '0;
        out_stall    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_GROUP;
        cfg_data     = '0;

        // hold reset, then release it on a falling edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, under the reset register values
        // empty payload: one frame on the start request, byte ignored
        send_request(1'b1, 11'd0, 64'd0, 8'hFF);
        // lengths over the limit: no frame, block stays idle
        send_request(1'b1, 11'd2047, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00);
        send_request(1'b1, MAX_PAYLOAD + 11'd1, 64'd1, 8'h12);
        // byte with no message open: ignored
        send_request(1'b0, 11'd0, 64'd0, 8'h00);
        // largest single frame, bytes alternating between the extremes
        for (int i = 0; i < 8; i++)
        begin
            send_request(i == 0, 11'd8, 64'hFFFF_FFFF_FFFF_FFFF, i[0] ? 8'hFF : 8'h00);
        end
        // shortest transport message: announce, full data frame, padded frame
        for (int i = 0; i < 9; i++)
        begin
            send_request(i == 0, 11'd9, 64'h0123_4567_89AB_CDEF, 8'(i * 37));
        end
        // new start while a message is open: the open one is dropped
        send_request(1'b1, 11'd15, 64'd5, 8'hAA);
        send_request(1'b0, 11'd0, 64'd0, 8'h55);
        send_request(1'b1, 11'd1, 64'd7, 8'h3C);
        drain();

        // Random part: one register setting per phase; phase 0 takes every
        // register to its top, phase 1 to zero, phase 3 runs with no idling
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 0)
            begin
                grp_val  = 32'hFFFF_FFFF;
                src_val  = 32'hFFFF_FFFF;
                prio_val = 32'hFFFF_FFFF;
                spc_val  = 32'hFFFF_FFFF;
            end
            else if (phase == 1)
            begin
                grp_val  = '0;
                src_val  = '0;
                prio_val = '0;
                spc_val  = '0;
            end
            else
            begin
                grp_val = $urandom;
                // half the time a broadcast group, else any format
                if ($urandom_range(1) == 1)
                begin
                    grp_val[15:12] = 4'hF;
                end
                src_val  = $urandom;
                prio_val = $urandom;
                spc_val  = ($urandom_range(1) == 1) ? $urandom : $urandom_range(1000);
            end
            write_reg(CFG_GROUP, grp_val);
            write_reg(CFG_SOURCE, src_val);
            write_reg(CFG_PRIO, prio_val);
            write_reg(CFG_SPACING, spc_val);
            calm = (phase == 3);

            // announce of the largest length under the top settings, then a
            // few data frames before the next start abandons it
            if (phase == 0)
            begin
                send_message(int'(MAX_PAYLOAD), LONG_CUT);
            end

            goal = msg_requests + PHASE_REQUESTS;
            while (msg_requests < goal)
            begin
                len = pick_len();
                cut = 2048;
                if (len > 1 && len <= int'(MAX_PAYLOAD) && $urandom_range(99) < 8)
                begin
                    cut = $urandom_range(len - 1, 1);
                end
                send_message(len, cut);
                // stray bytes, only once the message has closed
                if (cut == 2048 && $urandom_range(99) < 6)
                begin
                    repeat ($urandom_range(2, 1))
                    begin
                        send_request(1'b0, LEN_W'($urandom), {$urandom, $urandom},
                                     8'($urandom));
                    end
                end
            end
            drain();
            calm = 1'b0;
        end

        if (tracker.errors == 0 && tracker.frames_due.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/bseg_pkg.sv
rtl/core/bseg_cfg.sv
rtl/core/bseg_ingress.sv
rtl/core/bseg_engine.sv
rtl/core/j1939_bam_segmenter_top.sv
tb/tb_top.sv
